@@ rtl/core/wbt_pkg.sv @@
// Shared types and constants for the word boundary tokenizer.
// No dependencies; imported by wbt_classify, word_boundary_tokenizer and the testbench.
package wbt_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 32;
   localparam int unsigned LENGTH_W = 8;

   localparam logic [BYTE_W-1:0]   CHAR_NUL     = 8'h00;
   localparam logic [BYTE_W-1:0]   CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0]   CHAR_SPACE   = 8'h20;
   localparam logic [LENGTH_W-1:0] LENGTH_MAX   = 8'hFF;

   // scan mode of the word tracker
   typedef enum logic [1:0] {
      MODE_SEEK    = 2'd0,
      MODE_WORD    = 2'd1,
      MODE_DISCARD = 2'd2,
      MODE_IGNORE  = 2'd3
   } scan_mode_type;

   // C locale character classes of one byte
   typedef struct packed {
      logic is_nul;
      logic is_newline;
      logic is_letter;
      logic is_digit;
      logic is_space;
      logic is_punct;
   } char_class_type;

endpackage

@@ rtl/core/wbt_classify.sv @@
// Byte classifier: decodes one text byte into C locale classes.
// Depends on wbt_pkg.
module wbt_classify (
   input  logic [wbt_pkg::BYTE_W-1:0] char_byte,
   output wbt_pkg::char_class_type    char_class
);
   import wbt_pkg::*;

   always_comb begin
      char_class.is_nul     = (char_byte == CHAR_NUL);
      char_class.is_newline = (char_byte == CHAR_NEWLINE);
      char_class.is_letter  = (char_byte >= 8'd65 && char_byte <= 8'd90) ||
                              (char_byte >= 8'd97 && char_byte <= 8'd122);
      char_class.is_digit   = (char_byte >= 8'd48 && char_byte <= 8'd57);
      char_class.is_space   = (char_byte == CHAR_SPACE) ||
                              (char_byte >= 8'd9 && char_byte <= 8'd13);
      char_class.is_punct   = (char_byte >= 8'd33  && char_byte <= 8'd47)  ||
                              (char_byte >= 8'd58  && char_byte <= 8'd64)  ||
                              (char_byte >= 8'd91  && char_byte <= 8'd96)  ||
                              (char_byte >= 8'd123 && char_byte <= 8'd126);
   end

endmodule

@@ rtl/core/word_boundary_tokenizer.sv @@
// Word boundary tokenizer top level: byte stream in, word offset/length out.
// Depends on wbt_pkg and wbt_classify.
// ----------------------------------------------------------------------------
// Takes one text byte per transfer and emits one transfer per finished word:
// the offset of its first letter from the document start and its length from
// first to last letter. Letters open a word. Whitespace, or a second
// punctuation mark in a row, closes it. A digit kills the word up to the next
// whitespace. A NUL byte ignores the rest of its chunk. Chunks end at a
// newline, after CHUNK_BYTES bytes, or at tlast, and a word still open at a
// chunk end is dropped. tlast also restarts offsets at zero.
// Throughput is one byte per clock while no word is stalled. The byte is
// classified and the scan state updated in the accepting cycle, and a
// finished word lands in the output register on that edge. req_tready is high
// while that register is empty or being drained. While a word waits there
// with rsp_tready low, input is held off for every cycle of the stall.
// ----------------------------------------------------------------------------
module word_boundary_tokenizer #(
   parameter int unsigned CHUNK_BYTES = 255
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   // word stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] word_offset, [39:32] word_length
);
   import wbt_pkg::*;

   localparam int unsigned CW = $clog2(CHUNK_BYTES + 1);        // chunk position width
   localparam int unsigned LW = (CW + 1 > LENGTH_W) ? CW + 1 : LENGTH_W;

   // scan state
   scan_mode_type         mode_ff, mode_in;
   logic [CW-1:0]         chunk_pos_ff, chunk_pos_in;
   logic [OFFSET_W-1:0]   stream_pos_ff, stream_pos_in;
   logic [OFFSET_W-1:0]   word_begin_ff, word_begin_in;
   logic [CW-1:0]         begin_cp_ff, begin_cp_in;     // chunk position of first letter
   logic [CW-1:0]         last_cp_ff, last_cp_in;       // chunk position of last letter
   logic                  punct_ff, punct_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0]   rsp_offset_ff;
   logic [LENGTH_W-1:0]   rsp_length_ff;

   char_class_type        cls;
   logic                  req_xfer;
   logic                  emit;
   logic [CW:0]           cp_next;
   logic                  chunk_end;
   logic [CW:0]           len_wide;
   logic [LW-1:0]         len_ext;
   logic [LENGTH_W-1:0]   len_sat;

   wbt_classify u_classify (
      .char_byte  (req_tdata),
      .char_class (cls)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   // chunk boundary detection
   assign cp_next   = {1'b0, chunk_pos_ff} + (CW + 1)'(1);
   assign chunk_end = cls.is_newline || (cp_next >= (CW + 1)'(CHUNK_BYTES)) || req_tlast;

   // word length, saturated; a word never crosses a chunk so no wrap here
   assign len_wide = {1'b0, last_cp_ff - begin_cp_ff} + (CW + 1)'(1);
   assign len_ext  = LW'(len_wide);
   assign len_sat  = (len_ext > LW'(LENGTH_MAX)) ? LENGTH_MAX : len_ext[LENGTH_W-1:0];

   // next state and word close
   always_comb begin
      mode_in       = mode_ff;
      word_begin_in = word_begin_ff;
      begin_cp_in   = begin_cp_ff;
      last_cp_in    = last_cp_ff;
      punct_in      = punct_ff;
      emit          = 1'b0;

      case (mode_ff)
         MODE_SEEK: begin
            if (cls.is_nul) begin
               mode_in = MODE_IGNORE;
            end else if (cls.is_letter) begin
               mode_in       = MODE_WORD;
               word_begin_in = stream_pos_ff;
               begin_cp_in   = chunk_pos_ff;
               last_cp_in    = chunk_pos_ff;
               punct_in      = 1'b0;
            end
         end
         MODE_WORD: begin
            if (cls.is_nul) begin
               mode_in = MODE_IGNORE;
            end else if (cls.is_space || (cls.is_punct && punct_ff)) begin
               emit    = 1'b1;
               mode_in = MODE_SEEK;
            end else if (cls.is_digit) begin
               mode_in = MODE_DISCARD;
            end else begin
               if (cls.is_letter) begin
                  last_cp_in = chunk_pos_ff;
               end
               punct_in = cls.is_punct;
            end
         end
         MODE_DISCARD: begin
            if (cls.is_nul) begin
               mode_in = MODE_IGNORE;
            end else if (cls.is_space) begin
               mode_in = MODE_SEEK;
            end
         end
         default: begin
            // ignoring the rest of the chunk
         end
      endcase

      chunk_pos_in = cp_next[CW-1:0];
      if (chunk_end) begin
         mode_in      = MODE_SEEK;
         chunk_pos_in = '0;
         punct_in     = 1'b0;
      end
      stream_pos_in = req_tlast ? '0 : stream_pos_ff + OFFSET_W'(1);

      rsp_valid_in = (req_xfer && emit) || (rsp_valid_ff && !rsp_tready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SEEK;
         chunk_pos_ff  <= '0;
         stream_pos_ff <= '0;
         punct_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            mode_ff       <= mode_in;
            chunk_pos_ff  <= chunk_pos_in;
            stream_pos_ff <= stream_pos_in;
            punct_ff      <= punct_in;
         end
      end
   end

   // word tracking and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         word_begin_ff <= word_begin_in;
         begin_cp_ff   <= begin_cp_in;
         last_cp_ff    <= last_cp_in;
         if (emit) begin
            rsp_offset_ff <= word_begin_ff;
            rsp_length_ff <= len_sat;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_length_ff, rsp_offset_ff};

`ifndef ASSERT_OFF
   // a reported word always holds at least one letter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_length_ff != '0))
      else $error("word of zero length reported");

   // the final byte of a document restarts offsets and chunk position
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=> (stream_pos_ff == '0 && chunk_pos_ff == '0))
      else $error("offsets not restarted after end of text");

   // ignore mode never outlives its chunk, so it is never held at chunk position zero
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IGNORE) |-> (chunk_pos_ff != '0))
      else $error("ignore mode at chunk start");

   // a new word is only reported when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while result stalled");
`endif

endmodule

@@ verif/tb_word_boundary_tokenizer.sv @@
// Self-checking testbench for word_boundary_tokenizer: byte stream in, word offset/length out.
// Depends on wbt_pkg and the tokenizer RTL; holds its own behavioral model of the word rules.
module tb_word_boundary_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   import wbt_pkg::*;

   localparam int CHUNK_LEN   = 255;     // bytes per chunk when no newline comes first
   localparam int HOLD_CYCLES = 300;     // long receiver hold-off that backs up the block
   localparam int DRAIN_WAIT  = 32;      // settle time after the last expected word
   localparam int CYCLE_LIMIT = 200000;  // watchdog
   localparam int PHASE_ITEMS = 90;      // random bytes per idling phase
   localparam int HOLD_WORDS  = 24;      // short words offered during the hold-off

   // idling percentages: one side alone, both sides together
   localparam int ONE_SIDE_PCT  = 73;
   localparam int BOTH_SIDE_PCT = 36;

   typedef struct packed {
      logic [LENGTH_W-1:0] length;
      logic [OFFSET_W-1:0] offset;
   } word_type;

   // one directed transfer; typed rows carry a hand-written expectation
   typedef struct packed {
      logic [7:0] text;
      logic       eot;
      logic       typed;
      logic       has_word;
      word_type   word;
   } text_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] text_byte
   logic        req_tlast = 1'b0; // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] word_offset, [39:32] word_length

   // directed-row expectation riding along with the byte on the input
   logic     stim_typed = 1'b0;
   logic     stim_has = 1'b0;
   word_type stim_word = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int hold_count = 0;

   int bytes_sent = 0;
   int phase_start = 0;
   int error_count = 0;
   int cycle_count = 0;
   word_type pending_words[$];

   // tokenizer model state
   scan_mode_type       tok_mode = MODE_SEEK;
   int                  chunk_fill = 0;
   logic [OFFSET_W-1:0] doc_pos = '0;
   logic [OFFSET_W-1:0] first_letter = '0;
   logic [OFFSET_W-1:0] last_letter = '0;
   logic                after_punct = 1'b0;

   word_boundary_tokenizer #(
      .CHUNK_BYTES(CHUNK_LEN)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // C locale byte classes
   // ---------------------------------------------------------------------
   function automatic logic letter_byte(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic digit_byte(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic space_byte(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic punct_byte(input logic [7:0] b);
      return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
             (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
   endfunction

   // ---------------------------------------------------------------------
   // Word tracker: advance by one byte, return 1 when a word closes
   // ---------------------------------------------------------------------
   function automatic logic tokenize_byte(input logic [7:0] b, input logic eot,
                                          output word_type found);
      logic [OFFSET_W-1:0] here;
      logic [OFFSET_W-1:0] span;
      logic                closed;
      here   = doc_pos;
      closed = 1'b0;
      found  = '0;
      case (tok_mode)
         MODE_SEEK: begin
            if (b == CHAR_NUL) begin
               tok_mode = MODE_IGNORE;
            end else if (letter_byte(b)) begin
               tok_mode     = MODE_WORD;
               first_letter = here;
               last_letter  = here;
               after_punct  = 1'b0;
            end
         end
         MODE_WORD: begin
            if (b == CHAR_NUL) begin
               tok_mode = MODE_IGNORE;
            end else if (space_byte(b) || (punct_byte(b) && after_punct)) begin
               // trailing non-letters drop out: length runs to the last letter
               span         = last_letter - first_letter + 1;
               found.offset = first_letter;
               found.length = (span > 32'd255) ? LENGTH_MAX : span[LENGTH_W-1:0];
               closed       = 1'b1;
               tok_mode     = MODE_SEEK;
            end else if (digit_byte(b)) begin
               tok_mode = MODE_DISCARD;
            end else begin
               if (letter_byte(b)) last_letter = here;
               after_punct = punct_byte(b);
            end
         end
         MODE_DISCARD: begin
            if (b == CHAR_NUL) tok_mode = MODE_IGNORE;
            else if (space_byte(b)) tok_mode = MODE_SEEK;
         end
         default: ;
      endcase
      doc_pos    = here + 1;
      chunk_fill = chunk_fill + 1;
      // chunk end: newline, full chunk or end of document; an open word is lost
      if (b == CHAR_NEWLINE || chunk_fill >= CHUNK_LEN || eot) begin
         tok_mode    = MODE_SEEK;
         chunk_fill  = 0;
         after_punct = 1'b0;
      end
      if (eot) doc_pos = '0;
      return closed;
   endfunction

   // ---------------------------------------------------------------------
   // Byte pickers for the random text
   // ---------------------------------------------------------------------
   function automatic logic [7:0] pick_letter();
      int k;
      k = $urandom_range(51);
      return (k < 26) ? 8'(65 + k) : 8'(97 + k - 26);
   endfunction

   function automatic logic [7:0] pick_punct();
      int k;
      k = $urandom_range(31);
      if (k < 15) return 8'(33 + k);
      else if (k < 22) return 8'(58 + k - 15);
      else if (k < 28) return 8'(91 + k - 22);
      else return 8'(123 + k - 28);
   endfunction

   // whitespace other than newline, so the chunk keeps going
   function automatic logic [7:0] pick_space();
      int k;
      k = $urandom_range(4);
      case (k)
         0: return 8'd9;
         1: return 8'd11;
         2: return 8'd12;
         3: return 8'd13;
         default: return CHAR_SPACE;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Input driver: change at the falling edge, wait for the transfer
   // ---------------------------------------------------------------------
   task automatic send_row(input text_row_type row);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.text;
      req_tlast  <= row.eot;
      stim_typed <= row.typed;
      stim_has   <= row.has_word;
      stim_word  <= row.word;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eot);
      send_row(text_row_type'{b, eot, 1'b0, 1'b0, word_type'('0)});
   endtask

   // one random token: mostly well-formed words with random content, some noise
   task automatic send_token();
      int kind;
      int n;
      int k;
      kind = $urandom_range(99);
      if (kind < 70) begin
         n = $urandom_range(1, 10);
         send_byte(pick_letter(), 1'b0);
         for (int i = 1; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 80) send_byte(pick_letter(), 1'b0);
            else if (k < 88) send_byte(pick_punct(), 1'b0);
            else if (k < 94) send_byte(8'($urandom_range(127, 255)), 1'b0);
            else send_byte(8'($urandom_range(48, 57)), 1'b0);  // digit kills the word
         end
         // trailing marks: one is trimmed, a second in a row closes the word
         k = $urandom_range(99);
         if (k < 20) begin
            send_byte(pick_punct(), 1'b0);
         end else if (k < 30) begin
            send_byte(pick_punct(), 1'b0);
            send_byte(pick_punct(), 1'b0);
         end
         k = $urandom_range(99);
         if (k < 66) send_byte(pick_space(), 1'b0);
         else if (k < 80) send_byte(CHAR_NEWLINE, 1'b0);
         else if (k < 90) send_byte(pick_space(), 1'b1);   // document ends on the closer
         else if (k < 94) send_byte(pick_letter(), 1'b1);  // document ends mid-word
      end else if (kind < 80) begin
         send_byte(8'($urandom_range(255)), $urandom_range(99) < 5);
      end else if (kind < 88) begin
         send_byte(pick_space(), 1'b0);
      end else if (kind < 92) begin
         send_byte(CHAR_NUL, 1'b0);
      end else if (kind < 96) begin
         send_byte(CHAR_NEWLINE, 1'b0);
      end else begin
         send_byte(8'($urandom_range(33, 64)), 1'b0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off counted here
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Scoreboard: predict on each input transfer, check each output transfer.
   // Input first, so a same-edge result still finds its expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      word_type predicted;
      word_type due;
      logic     closes;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("watchdog expired with %0d words outstanding", pending_words.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            closes = tokenize_byte(req_tdata, req_tlast, predicted);
            if (stim_typed) begin
               closes    = stim_has;
               predicted = stim_word;
            end
            if (closes) pending_words.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               $error("unexpected word: offset %0d length %0d",
                      rsp_tdata[31:0], rsp_tdata[39:32]);
               error_count++;
            end else begin
               due = pending_words.pop_front();
               if (rsp_tdata[31:0] !== due.offset) begin
                  $error("word_offset: expected %0d, got %0d", due.offset, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[39:32] !== due.length) begin
                  $error("word_length: expected %0d, got %0d", due.length, rsp_tdata[39:32]);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed text: one short document, then a second one after end of text.
   // Typed rows are the words the rules give at a glance.
   // ---------------------------------------------------------------------
   text_row_type directed_rows[27] = '{
      '{"A",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"z",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{" ",   1'b0, 1'b1, 1'b1, '{8'd2, 32'd0}},   // plain word closed by space
      '{"a",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"!",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"~",   1'b0, 1'b1, 1'b1, '{8'd1, 32'd3}},   // second mark closes, first trimmed
      '{"b",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"9",   1'b0, 1'b0, 1'b0, word_type'('0)},   // digit discards the word
      '{"q",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{8'h09, 1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"Z",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{8'hFF, 1'b0, 1'b0, 1'b0, word_type'('0)},   // classless bytes are trimmed
      '{8'h80, 1'b0, 1'b0, 1'b0, word_type'('0)},
      '{8'h0D, 1'b0, 1'b1, 1'b1, '{8'd1, 32'd10}},
      '{"x",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{8'h00, 1'b0, 1'b0, 1'b0, word_type'('0)},   // NUL drops the word, mutes the chunk
      '{"y",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{" ",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"k",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{8'h0A, 1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"M",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"n",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{8'h0A, 1'b0, 1'b1, 1'b1, '{8'd2, 32'd20}},  // newline both closes and cuts
      '{"p",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{"q",   1'b1, 1'b0, 1'b0, word_type'('0)},   // end of text drops the open word
      '{"G",   1'b0, 1'b0, 1'b0, word_type'('0)},
      '{" ",   1'b0, 1'b1, 1'b1, '{8'd1, 32'd0}}    // offsets restart at zero
   };

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_row(directed_rows[i]);

      // idling per phase: none, sender only, receiver only, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? ONE_SIDE_PCT : ((phase == 3) ? BOTH_SIDE_PCT : 0);
         stall_pct     = (phase == 2) ? ONE_SIDE_PCT : ((phase == 3) ? BOTH_SIDE_PCT : 0);
         if (phase == 3) begin
            // longest word a full chunk allows, closed by the chunk's last byte
            send_byte(CHAR_NEWLINE, 1'b0);
            for (int i = 0; i < CHUNK_LEN - 1; i++) send_byte(pick_letter(), 1'b0);
            send_byte(CHAR_SPACE, 1'b0);
         end
         phase_start = bytes_sent;
         while (bytes_sent < phase_start + PHASE_ITEMS) send_token();
      end

      // back-pressure: receiver holds off while short words keep coming,
      // so the output register fills and the input stalls
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_go       = 1'b1;
      send_byte(CHAR_NEWLINE, 1'b0);
      for (int i = 0; i < HOLD_WORDS; i++) begin
         send_byte("a", 1'b0);
         send_byte("b", 1'b0);
         send_byte("c", 1'b0);
         send_byte(CHAR_SPACE, 1'b0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/wbt_pkg.sv
rtl/core/wbt_classify.sv
rtl/core/word_boundary_tokenizer.sv
verif/tb_word_boundary_tokenizer.sv
